@@ src/bwu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bwu_pkg;

    // field widths
    localparam int ACTION_W = 3;
    localparam int SLOT_W   = 4;
    localparam int ADDR_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int MODE_W   = 4;
    localparam int CAUSE_W  = 3;

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 32;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_CHECK       = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_SET_EXEC    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR_EXEC  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SET_WATCH   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR_WATCH = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_SET_OPCODE  = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_SET_STEP    = 3'd6;

    // addressing modes
    localparam logic [MODE_W-1:0] MODE_IMPL = 4'd0;
    localparam logic [MODE_W-1:0] MODE_ACC  = 4'd1;
    localparam logic [MODE_W-1:0] MODE_IMM  = 4'd2;
    localparam logic [MODE_W-1:0] MODE_ZP   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_ZPX  = 4'd4;
    localparam logic [MODE_W-1:0] MODE_ZPY  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_ABS  = 4'd6;
    localparam logic [MODE_W-1:0] MODE_ABX  = 4'd7;
    localparam logic [MODE_W-1:0] MODE_ABY  = 4'd8;
    localparam logic [MODE_W-1:0] MODE_INDX = 4'd9;
    localparam logic [MODE_W-1:0] MODE_INDY = 4'd10;
    localparam logic [MODE_W-1:0] MODE_IND  = 4'd11;
    localparam logic [MODE_W-1:0] MODE_REL  = 4'd12;

    // hit causes
    localparam logic [CAUSE_W-1:0] CAUSE_NONE   = 3'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_EXEC   = 3'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_WATCH  = 3'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_OPCODE = 3'd3;
    localparam logic [CAUSE_W-1:0] CAUSE_STEP   = 3'd4;
    localparam logic [CAUSE_W-1:0] CAUSE_STOP   = 3'd5;

    // last zero-page byte
    localparam logic [BYTE_W-1:0] ZP_LAST = 8'hFF;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic do_addr;
        logic do_match;
        logic load_out;
    } bwu_cmd_t;

    // address generator result
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] ea;
        logic              wrap_zp;
        logic              wrap_full;
    } bwu_addr_t;

endpackage

`default_nettype wire

@@ src/bwu_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bwu_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    output bwu_pkg::bwu_cmd_t cmd
);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_ADDR    = 2'd1;
    localparam logic [1:0] S_MATCH   = 2'd2;
    localparam logic [1:0] S_RESOLVE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // output slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_ADDR;
                end
            end
            S_ADDR:
            begin
                cmd.do_addr = 1'b1;
                state_next  = S_MATCH;
            end
            S_MATCH:
            begin
                cmd.do_match = 1'b1;
                state_next   = S_RESOLVE;
            end
            S_RESOLVE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ src/bwu_addr_gen.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bwu_addr_gen (
    input  wire logic [bwu_pkg::MODE_W-1:0] mode,
    input  wire logic [bwu_pkg::BYTE_W-1:0] operand_lo,
    input  wire logic [bwu_pkg::BYTE_W-1:0] operand_hi,
    input  wire logic [bwu_pkg::BYTE_W-1:0] index_x,
    input  wire logic [bwu_pkg::BYTE_W-1:0] index_y,
    input  wire logic [bwu_pkg::ADDR_W-1:0] pointer_word,
    output bwu_pkg::bwu_addr_t              addr
);

    logic [bwu_pkg::BYTE_W:0] zp_sum_x;
    logic [bwu_pkg::BYTE_W:0] zp_sum_y;
    logic [bwu_pkg::ADDR_W:0] abs_sum_x;
    logic [bwu_pkg::ADDR_W:0] abs_sum_y;
    logic [bwu_pkg::ADDR_W:0] ptr_sum_y;
    logic [bwu_pkg::ADDR_W-1:0] abs_addr;

    assign abs_addr  = {operand_hi, operand_lo};
    assign zp_sum_x  = {1'b0, operand_lo} + {1'b0, index_x};
    assign zp_sum_y  = {1'b0, operand_lo} + {1'b0, index_y};
    assign abs_sum_x = {1'b0, abs_addr} + {9'd0, index_x};
    assign abs_sum_y = {1'b0, abs_addr} + {9'd0, index_y};
    assign ptr_sum_y = {1'b0, pointer_word} + {9'd0, index_y};

    always_comb
    begin
        addr = '0;
        unique case (mode)
            bwu_pkg::MODE_ZP:
            begin
                addr.valid = 1'b1;
                addr.ea    = {8'd0, operand_lo};
            end
            bwu_pkg::MODE_ZPX:
            begin
                addr.valid   = 1'b1;
                addr.ea      = {8'd0, zp_sum_x[bwu_pkg::BYTE_W-1:0]};
                addr.wrap_zp = zp_sum_x[bwu_pkg::BYTE_W];
            end
            bwu_pkg::MODE_ZPY:
            begin
                addr.valid   = 1'b1;
                addr.ea      = {8'd0, zp_sum_y[bwu_pkg::BYTE_W-1:0]};
                addr.wrap_zp = zp_sum_y[bwu_pkg::BYTE_W];
            end
            bwu_pkg::MODE_ABS:
            begin
                addr.valid = 1'b1;
                addr.ea    = abs_addr;
            end
            bwu_pkg::MODE_ABX:
            begin
                addr.valid     = 1'b1;
                addr.ea        = abs_sum_x[bwu_pkg::ADDR_W-1:0];
                addr.wrap_full = abs_sum_x[bwu_pkg::ADDR_W];
            end
            bwu_pkg::MODE_ABY:
            begin
                addr.valid     = 1'b1;
                addr.ea        = abs_sum_y[bwu_pkg::ADDR_W-1:0];
                addr.wrap_full = abs_sum_y[bwu_pkg::ADDR_W];
            end
            bwu_pkg::MODE_INDX:
            begin
                // pointer high byte wraps once the indexed zero-page sum reaches the page end or carries past it
                addr.valid   = 1'b1;
                addr.ea      = pointer_word;
                addr.wrap_zp = (zp_sum_x >= {1'b0, bwu_pkg::ZP_LAST});
            end
            bwu_pkg::MODE_INDY:
            begin
                addr.valid     = 1'b1;
                addr.ea        = ptr_sum_y[bwu_pkg::ADDR_W-1:0];
                addr.wrap_zp   = (operand_lo == bwu_pkg::ZP_LAST);
                addr.wrap_full = ptr_sum_y[bwu_pkg::ADDR_W];
            end
            default:
            begin
                addr = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/bwu_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bwu_datapath #(
    parameter int SLOT_COUNT = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire bwu_pkg::bwu_cmd_t                cmd,
    input  wire logic [bwu_pkg::IN_DATA_W-1:0]    in_data,
    input  wire logic [bwu_pkg::ACTION_W-1:0]     in_user,
    input  wire logic                             cfg_write,
    input  wire logic [bwu_pkg::ADDR_W-1:0]       cfg_data,
    output logic      [bwu_pkg::OUT_DATA_W-1:0]   out_data
);

    localparam int OPC_DEPTH = 1 << bwu_pkg::BYTE_W;

    // captured item
    logic [bwu_pkg::ACTION_W-1:0] action_reg;
    logic [bwu_pkg::SLOT_W-1:0]   slot_reg;
    logic [bwu_pkg::ADDR_W-1:0]   pc_reg;
    logic [bwu_pkg::BYTE_W-1:0]   opcode_reg;
    logic [bwu_pkg::MODE_W-1:0]   mode_reg;
    logic [bwu_pkg::BYTE_W-1:0]   operand_lo_reg;
    logic [bwu_pkg::BYTE_W-1:0]   operand_hi_reg;
    logic [bwu_pkg::BYTE_W-1:0]   index_x_reg;
    logic [bwu_pkg::BYTE_W-1:0]   index_y_reg;
    logic [bwu_pkg::ADDR_W-1:0]   pointer_word_reg;
    logic [bwu_pkg::ADDR_W-1:0]   target_low_reg;
    logic [bwu_pkg::ADDR_W-1:0]   target_high_reg;

    // address stage
    bwu_pkg::bwu_addr_t           addr;
    logic                         is_check_reg;
    logic                         addr_valid_reg;
    logic [bwu_pkg::ADDR_W-1:0]   ea_reg;
    logic                         wrap_zp_reg;
    logic                         wrap_full_reg;
    logic                         is_check;
    logic                         slot_ok;

    // tables
    logic [SLOT_COUNT-1:0]        exec_valid_reg;
    logic [bwu_pkg::ADDR_W-1:0]   exec_addr_reg [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]        watch_valid_reg;
    logic [bwu_pkg::ADDR_W-1:0]   watch_low_reg [SLOT_COUNT];
    logic [bwu_pkg::ADDR_W-1:0]   watch_high_reg [SLOT_COUNT];
    logic [OPC_DEPTH-1:0]         opcode_mask_reg;
    logic [bwu_pkg::ADDR_W-1:0]   step_target_reg;
    logic [bwu_pkg::ADDR_W-1:0]   stop_address_reg;

    // match stage
    logic [SLOT_COUNT-1:0]        exec_match_reg;
    logic [SLOT_COUNT-1:0]        watch_match_reg;
    logic                         opcode_match_reg;
    logic                         step_match_reg;
    logic                         stop_match_reg;

    // resolve
    logic                         hit;
    logic [bwu_pkg::CAUSE_W-1:0]  hit_cause;
    logic [bwu_pkg::SLOT_W-1:0]   hit_slot;
    logic [bwu_pkg::OUT_DATA_W-1:0] out_data_next;
    logic [bwu_pkg::OUT_DATA_W-1:0] out_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            action_reg       <= in_user;
            slot_reg         <= in_data[3:0];
            pc_reg           <= in_data[19:4];
            opcode_reg       <= in_data[27:20];
            mode_reg         <= in_data[31:28];
            operand_lo_reg   <= in_data[39:32];
            operand_hi_reg   <= in_data[47:40];
            index_x_reg      <= in_data[55:48];
            index_y_reg      <= in_data[63:56];
            pointer_word_reg <= in_data[79:64];
            target_low_reg   <= in_data[95:80];
            target_high_reg  <= in_data[111:96];
        end
    end

    bwu_addr_gen u_addr_gen (
        .mode         (mode_reg),
        .operand_lo   (operand_lo_reg),
        .operand_hi   (operand_hi_reg),
        .index_x      (index_x_reg),
        .index_y      (index_y_reg),
        .pointer_word (pointer_word_reg),
        .addr         (addr)
    );

    assign is_check = (action_reg == bwu_pkg::ACT_CHECK);
    assign slot_ok  = ({28'd0, slot_reg} < 32'(SLOT_COUNT));

    always_ff @(posedge clk)
    begin
        if (cmd.do_addr)
        begin
            is_check_reg   <= is_check;
            addr_valid_reg <= is_check && addr.valid;
            ea_reg         <= is_check ? addr.ea : '0;
            wrap_zp_reg    <= is_check && addr.wrap_zp;
            wrap_full_reg  <= is_check && addr.wrap_full;
        end
    end

    // table edits happen in the address cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_valid_reg   <= '0;
            watch_valid_reg  <= '0;
            opcode_mask_reg  <= '0;
            step_target_reg  <= '0;
            stop_address_reg <= '0;
        end
        else
        begin
            if (cfg_write)
                stop_address_reg <= cfg_data;
            if (cmd.do_addr)
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (slot_ok && (32'(slot_reg) == i))
                    begin
                        if (action_reg == bwu_pkg::ACT_SET_EXEC)
                            exec_valid_reg[i] <= 1'b1;
                        else if (action_reg == bwu_pkg::ACT_CLEAR_EXEC)
                            exec_valid_reg[i] <= 1'b0;
                        if (action_reg == bwu_pkg::ACT_SET_WATCH)
                            watch_valid_reg[i] <= 1'b1;
                        else if (action_reg == bwu_pkg::ACT_CLEAR_WATCH)
                            watch_valid_reg[i] <= 1'b0;
                    end
                end
                if (action_reg == bwu_pkg::ACT_SET_OPCODE)
                    opcode_mask_reg[opcode_reg] <= 1'b1;
                if (action_reg == bwu_pkg::ACT_SET_STEP)
                    step_target_reg <= target_low_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_addr)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                if (slot_ok && (32'(slot_reg) == i))
                begin
                    if (action_reg == bwu_pkg::ACT_SET_EXEC)
                        exec_addr_reg[i] <= target_low_reg;
                    if (action_reg == bwu_pkg::ACT_SET_WATCH)
                    begin
                        watch_low_reg[i]  <= target_low_reg;
                        watch_high_reg[i] <= target_high_reg;
                    end
                end
            end
        end
    end

    // all slots compared side by side
    always_ff @(posedge clk)
    begin
        if (cmd.do_match)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                exec_match_reg[i]  <= exec_valid_reg[i] && (exec_addr_reg[i] == pc_reg);
                watch_match_reg[i] <= addr_valid_reg && watch_valid_reg[i] &&
                                      (watch_low_reg[i] <= ea_reg) &&
                                      (watch_high_reg[i] >= ea_reg);
            end
            opcode_match_reg <= opcode_mask_reg[opcode_reg];
            step_match_reg   <= (pc_reg == step_target_reg);
            stop_match_reg   <= (pc_reg == stop_address_reg);
        end
    end

    // lowest slot wins, exec before watch within a slot
    always_comb
    begin
        hit       = 1'b0;
        hit_cause = bwu_pkg::CAUSE_NONE;
        hit_slot  = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (exec_match_reg[i])
            begin
                hit       = 1'b1;
                hit_cause = bwu_pkg::CAUSE_EXEC;
                hit_slot  = 4'(i);
            end
            else if (watch_match_reg[i])
            begin
                hit       = 1'b1;
                hit_cause = bwu_pkg::CAUSE_WATCH;
                hit_slot  = 4'(i);
            end
        end
        if (!hit)
        begin
            priority if (opcode_match_reg)
            begin
                hit       = 1'b1;
                hit_cause = bwu_pkg::CAUSE_OPCODE;
            end
            else if (step_match_reg)
            begin
                hit       = 1'b1;
                hit_cause = bwu_pkg::CAUSE_STEP;
            end
            else if (stop_match_reg)
            begin
                hit       = 1'b1;
                hit_cause = bwu_pkg::CAUSE_STOP;
            end
            else
            begin
                hit = 1'b0;
            end
        end
        if (!is_check_reg)
        begin
            hit       = 1'b0;
            hit_cause = bwu_pkg::CAUSE_NONE;
            hit_slot  = '0;
        end
    end

    assign out_data_next = {5'd0, wrap_full_reg, wrap_zp_reg, ea_reg, addr_valid_reg,
                            hit_slot, hit_cause, hit};

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
            out_data_reg <= out_data_next;
    end

    assign out_data = out_data_reg;

endmodule

`default_nettype wire

@@ src/breakpoint_watchpoint_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// breakpoint / watchpoint unit: each stream transaction on the slave side carries one
// item whose kind (check, set or clear exec slot, set or clear watch range, mark opcode,
// set step target) sits in s_axis_tuser; every item yields exactly one result transaction
// on the master side, all zero for table edits. a check item forms the data effective
// address from the addressing mode, flags zero-page and full-space wraps, and tests the
// instruction against SLOT_COUNT exec breakpoints, SLOT_COUNT inclusive watch ranges, the
// 256-entry opcode mask, the step target and the stop address; lowest slot wins (exec before
// watch in a slot), then opcode, step, stop. stages: capture, address generation and table
// edit, parallel slot compare into registered match bits, priority resolve into the output
// register once it is free. the next item is taken right after resolve, while a finished
// result may still wait in the output register. stop_address is written through the cfg
// channel (always ready); the user must do so only while the unit is idle, as the unit does
// not enforce it. tables and stop address clear on reset.

module breakpoint_watchpoint_unit #(
    parameter int SLOT_COUNT = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,

    // item input
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // slot[3:0], pc[19:4], opcode[27:20], mode[31:28], operand_lo[39:32],
    // operand_hi[47:40], index_x[55:48], index_y[63:56], pointer_word[79:64],
    // target_low[95:80], target_high[111:96]
    input  wire logic [111:0] s_axis_tdata,
    // action[2:0]
    input  wire logic [2:0]   s_axis_tuser,

    // result output
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // hit[0], hit_cause[3:1], hit_slot[7:4], address_valid[8],
    // effective_address[24:9], wrap_zero_page[25], wrap_full_space[26], zero fill above
    output logic [31:0]       m_axis_tdata,

    // stop address write
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [15:0]  cfg_data
);

    bwu_pkg::bwu_cmd_t cmd;

    // register write never stalls
    assign cfg_ready = 1'b1;

    bwu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    bwu_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire
